FILE: design/vpri_pkg.sv
// ----------------------------------------------------------------------------
// Video port register interface package
// Shared sizes, operation and code encodings, and the request structs that
// pass between the port controller and its memories.
// ----------------------------------------------------------------------------
package vpri_pkg;

  localparam int unsigned VMEM_ADDR_BITS = 14;
  localparam int unsigned CMEM_DEPTH     = 32;
  localparam int unsigned REG_COUNT      = 12;

  localparam int unsigned VMEM_DEPTH     = 1 << VMEM_ADDR_BITS;
  localparam int unsigned CMEM_ADDR_BITS = $clog2(CMEM_DEPTH);
  localparam int unsigned REG_IDX_BITS   = $clog2(REG_COUNT);

  localparam int unsigned PORT_ADDR_BITS = 14;
  localparam int unsigned BYTE_BITS      = 8;
  localparam int unsigned IN_TDATA_BITS  = 16;
  localparam int unsigned OUT_TDATA_BITS = 16;

  // Display register numbers that the port logic looks at.
  localparam logic [REG_IDX_BITS-1:0] REG_MODE_0 = REG_IDX_BITS'(0);
  localparam logic [REG_IDX_BITS-1:0] REG_MODE_1 = REG_IDX_BITS'(1);

  // Status byte masks applied after a status read.
  localparam logic [BYTE_BITS-1:0] STATUS_KEEP_MODE2 = 8'h2F;
  localparam logic [BYTE_BITS-1:0] STATUS_KEEP_OTHER = 8'h1F;

  typedef enum logic [2:0] {
    OP_CTRL_WRITE  = 3'd0,
    OP_DATA_WRITE  = 3'd1,
    OP_DATA_READ   = 3'd2,
    OP_STATUS_READ = 3'd3,
    OP_FLAG_EVENT  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CODE_VMEM_READ  = 2'd0,
    CODE_VMEM_WRITE = 2'd1,
    CODE_REG_WRITE  = 2'd2,
    CODE_CMEM_WRITE = 2'd3
  } code_e;

  typedef struct packed {
    op_e                  op;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 set_frame_flag;
    logic                 set_overflow_flag;
    logic                 set_collision_flag;
  } item_t;

  typedef struct packed {
    logic                      we;
    logic [VMEM_ADDR_BITS-1:0] waddr;
    logic [BYTE_BITS-1:0]      wdata;
    logic                      re;
    logic [VMEM_ADDR_BITS-1:0] raddr;
  } vmem_req_t;

  typedef struct packed {
    logic                      we;
    logic [CMEM_ADDR_BITS-1:0] waddr;
    logic [BYTE_BITS-1:0]      wdata;
  } cmem_req_t;

endpackage

FILE: design/vpri_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module vpri_ram #(
  parameter int unsigned WIDTH     = 8,
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/vpri_core.sv
// ----------------------------------------------------------------------------
// Video port controller
// Decodes port accesses, keeps the address latch, read buffer, status flags
// and display registers, and drives the memory ports and the result register.
// ----------------------------------------------------------------------------
module vpri_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [vpri_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [vpri_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata_o,
  output vpri_pkg::vmem_req_t                 vmem_req_o,
  input  logic [vpri_pkg::BYTE_BITS-1:0]      vmem_rdata_i,
  output vpri_pkg::cmem_req_t                 cmem_req_o
);
  import vpri_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e                    state_q, state_d;
  logic [VMEM_ADDR_BITS-1:0] clr_cnt_q, clr_cnt_d;
  item_t                     item_q, in_item;

  logic [PORT_ADDR_BITS-1:0] addr_q, addr_d;
  code_e                     code_q, code_d;
  logic                      pend_q, pend_d;
  logic [BYTE_BITS-1:0]      pre_q, pre_d;
  logic [BYTE_BITS-1:0]      stat_q, stat_d;
  logic                      irq_q, irq_d;
  logic [BYTE_BITS-1:0]      regs_q [REG_COUNT];
  logic [BYTE_BITS-1:0]      regs_d [REG_COUNT];

  logic                      out_valid_q;
  logic [BYTE_BITS-1:0]      out_data_q;
  logic                      out_irq_q;

  logic                      in_acc, commit, clearing;
  logic [PORT_ADDR_BITS-1:0] rd_addr, hi_addr;
  logic [3:0]                reg_id;
  logic [BYTE_BITS-1:0]      result;
  logic                      vmem_we, cmem_we, mode_two;

  assign clearing        = (state_q == ST_CLEAR);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign commit          = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    in_item.op                 = op_e'(s_axis_tdata_i[2:0]);
    in_item.data_byte          = s_axis_tdata_i[10:3];
    in_item.set_frame_flag     = s_axis_tdata_i[11];
    in_item.set_overflow_flag  = s_axis_tdata_i[12];
    in_item.set_collision_flag = s_axis_tdata_i[13];
  end

  // The read is issued when the beat is taken; a second control byte reads
  // at the address that it completes.
  assign rd_addr = (in_item.op == OP_CTRL_WRITE) ?
                   {in_item.data_byte[5:0], addr_q[7:0]} : addr_q;

  assign hi_addr  = {item_q.data_byte[5:0], addr_q[7:0]};
  assign reg_id   = item_q.data_byte[3:0];
  assign mode_two = !regs_q[REG_MODE_0][2] && !regs_q[REG_MODE_1][3] &&
                    regs_q[REG_MODE_0][1] && !regs_q[REG_MODE_1][4];

  always_comb begin
    addr_d  = addr_q;
    code_d  = code_q;
    pend_d  = pend_q;
    pre_d   = pre_q;
    stat_d  = stat_q;
    irq_d   = irq_q;
    regs_d  = regs_q;
    result  = '0;
    vmem_we = 1'b0;
    cmem_we = 1'b0;
    unique case (item_q.op)
      OP_CTRL_WRITE: begin
        if (pend_q) begin
          pend_d = 1'b0;
          code_d = code_e'(item_q.data_byte[7:6]);
          addr_d = hi_addr;
          if (code_d == CODE_VMEM_READ) begin
            pre_d  = vmem_rdata_i;
            addr_d = hi_addr + PORT_ADDR_BITS'(1);
          end else if (code_d == CODE_REG_WRITE) begin
            for (int unsigned i = 0; i < REG_COUNT; i++) begin
              if (reg_id == 4'(i)) begin
                regs_d[i] = addr_q[7:0];
              end
            end
            if (reg_id == 4'(REG_MODE_1) && stat_q[7] && addr_q[5]) begin
              irq_d = 1'b1;
            end
          end
        end else begin
          addr_d = {addr_q[PORT_ADDR_BITS-1:8], item_q.data_byte};
          pend_d = 1'b1;
        end
      end
      OP_DATA_WRITE: begin
        pend_d = 1'b0;
        if (code_q == CODE_CMEM_WRITE) begin
          cmem_we = 1'b1;
        end else begin
          vmem_we = 1'b1;
        end
        pre_d  = item_q.data_byte;
        addr_d = addr_q + PORT_ADDR_BITS'(1);
      end
      OP_DATA_READ: begin
        pend_d = 1'b0;
        result = pre_q;
        pre_d  = vmem_rdata_i;
        addr_d = addr_q + PORT_ADDR_BITS'(1);
      end
      OP_STATUS_READ: begin
        result = stat_q;
        pend_d = 1'b0;
        irq_d  = 1'b0;
        stat_d = stat_q & (mode_two ? STATUS_KEEP_MODE2 : STATUS_KEEP_OTHER);
      end
      OP_FLAG_EVENT: begin
        stat_d = stat_q | {item_q.set_frame_flag, item_q.set_overflow_flag,
                           item_q.set_collision_flag, 5'b0};
        if (stat_d[7] && regs_q[REG_MODE_1][5]) begin
          irq_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Video memory port; the clearing pass owns the write side after reset.
  always_comb begin
    vmem_req_o.we    = clearing || (commit && vmem_we);
    vmem_req_o.waddr = clearing ? clr_cnt_q : VMEM_ADDR_BITS'(addr_q);
    vmem_req_o.wdata = clearing ? '0 : item_q.data_byte;
    vmem_req_o.re    = in_acc;
    vmem_req_o.raddr = VMEM_ADDR_BITS'(rd_addr);
    cmem_req_o.we    = clearing || (commit && cmem_we);
    cmem_req_o.waddr = clearing ? CMEM_ADDR_BITS'(clr_cnt_q) : CMEM_ADDR_BITS'(addr_q);
    cmem_req_o.wdata = clearing ? '0 : item_q.data_byte;
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + VMEM_ADDR_BITS'(1);
        if (clr_cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      addr_q      <= '0;
      code_q      <= CODE_VMEM_READ;
      pend_q      <= 1'b0;
      pre_q       <= '0;
      stat_q      <= '0;
      irq_q       <= 1'b0;
      regs_q      <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      if (commit) begin
        addr_q      <= addr_d;
        code_q      <= code_d;
        pend_q      <= pend_d;
        pre_q       <= pre_d;
        stat_q      <= stat_d;
        irq_q       <= irq_d;
        regs_q      <= regs_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item;
    end
    if (commit) begin
      out_data_q <= result;
      out_irq_q  <= irq_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_irq_q, out_data_q};

endmodule

FILE: design/video_port_register_interface_top.sv
// ----------------------------------------------------------------------------
// Video port register interface
// CPU-side port of a video display processor with video and colour memory.
// ----------------------------------------------------------------------------
// Each access beat is taken in the idle state, which issues the video memory
// read; the execute state, once the read data is back and the result
// register is free, updates the port state, writes memory and loads the
// result register. A new beat is taken while the previous result still waits
// downstream. After reset a clearing pass zeroes the video and colour
// memories one entry per cycle; s_axis_tready stays low until it is done.
module video_port_register_interface_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [2:0] op, [10:3] data_byte, [11] set_frame_flag, [12] set_overflow_flag,
  // [13] set_collision_flag, [15:14] zero
  input  logic [vpri_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] read_data, [8] irq_request, [15:9] zero
  output logic [vpri_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);
  import vpri_pkg::*;

  vmem_req_t            vmem_req;
  cmem_req_t            cmem_req;
  logic [BYTE_BITS-1:0] vmem_rdata;

  vpri_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .vmem_req_o      (vmem_req),
    .vmem_rdata_i    (vmem_rdata),
    .cmem_req_o      (cmem_req)
  );

  vpri_ram #(
    .WIDTH (BYTE_BITS),
    .DEPTH (VMEM_DEPTH)
  ) u_vmem (
    .clk_i   (clk_i),
    .we_i    (vmem_req.we),
    .waddr_i (vmem_req.waddr),
    .wdata_i (vmem_req.wdata),
    .re_i    (vmem_req.re),
    .raddr_i (vmem_req.raddr),
    .rdata_o (vmem_rdata)
  );

  // Colour memory is write-only from the CPU port.
  vpri_ram #(
    .WIDTH (BYTE_BITS),
    .DEPTH (CMEM_DEPTH)
  ) u_cmem (
    .clk_i   (clk_i),
    .we_i    (cmem_req.we),
    .waddr_i (cmem_req.waddr),
    .wdata_i (cmem_req.wdata),
    .re_i    (1'b0),
    .raddr_i ('0),
    .rdata_o ()
  );

endmodule

FILE: design/vpri_checker.sv
// ----------------------------------------------------------------------------
// Video port register interface checker
// Port-level properties of the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
module vpri_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic [vpri_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [vpri_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);
  import vpri_pkg::*;

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // A held result keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // The block works on one beat at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready)
    else $error("second input beat taken while one is in flight");

  // With the output side empty, the result of a beat becomes valid without a stall.
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && !m_axis_tvalid |-> ##2 m_axis_tvalid)
    else $error("result beat did not appear on time");

  // The padding above the result fields stays zero.
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_BITS-1:9] == '0)
    else $error("result padding bits are not zero");

endmodule

bind video_port_register_interface_top vpri_checker u_checker (.*);
